// ----- rtl/core/ubd_pkg.sv -----
// ----------------------------------------------------------------------------
// ubd_pkg
// Shared types and constants for the UART baud divisor calculator.
// ----------------------------------------------------------------------------
package ubd_pkg;

    localparam int CLOCK_W   = 28;
    localparam int BAUD_W    = 24;
    localparam int NUMER_W   = 32;   // clock_hz*25 after the mode shift
    localparam int PROD_W    = 33;   // clock_hz*25 before the mode shift
    localparam int REM_W     = 7;    // remainder modulo 100
    localparam int MANT_W    = 26;   // full mantissa before masking
    localparam int WORD_W    = 16;
    localparam int FRAC_W    = 4;
    localparam int NUM_CELLS = NUMER_W;
    localparam int LATENCY   = NUM_CELLS + 2;

    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 3;

    localparam logic [CLOCK_W-1:0] CLOCK_RESET = 28'd16000000;
    localparam logic [4:0]         SCALE_NUM   = 5'd25;
    localparam logic [7:0]         PCT         = 8'd100;
    localparam logic [10:0]        HALF_PCT    = 11'd50;
    localparam logic [3:0]         FRAC8_MASK  = 4'h7;
    localparam logic [3:0]         FRAC16_MASK = 4'hF;
    localparam logic [11:0]        MANT_MASK   = 12'hFFF;
    localparam logic [4:0]         STEPS_8     = 5'd8;
    localparam logic [4:0]         STEPS_16    = 5'd16;

    // floor(t/100) == (t*1311) >> 17 for every t below 2048
    localparam logic [10:0]        RECIP_100   = 11'd1311;
    localparam int                 RECIP_SHIFT = 17;

    typedef enum logic {
        REG_CLOCK_HZ   = 1'b0,
        REG_OVERSAMPLE = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic                  ob8;
        logic [BAUD_W-1:0]     baud;
        logic [NUMER_W-1:0]    numer;   // dividend bits still to be consumed, MSB first
        logic [BAUD_W-1:0]     prem;    // partial remainder of numer / baud
        logic [REM_W-1:0]      rem100;  // running quotient modulo 100
        logic [MANT_W-1:0]     mant;    // running quotient / 100
    } t_cell_data;

endpackage

// ----- rtl/core/uart_baud_divisor_calc_top.sv -----
// ----------------------------------------------------------------------------
// uart_baud_divisor_calc_top
// Computes the UART fractional baud divisor word for a requested baud rate.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                        Payload
//  request   in         start && !busy                   i_baud_rate
//  result    out        o_done (one-cycle strobe)        o_divisor_word, o_mantissa_clipped
//  config    in         APB write: psel,penable,pwrite   paddr, pwdata / prdata
//
//  A request enters every cycle; busy never rises.
//  Each result passes through a front register that forms the dividend,
//  32 divider cells that each retire one quotient bit, and a register that rounds.
//  Throughput is one per cycle.
//  Reset empties the pipeline and loads clock_hz = 16000000, oversampling by 16.
//  The receiver cannot stall; results are not held.
// ----------------------------------------------------------------------------
module uart_baud_divisor_calc_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [ubd_pkg::BAUD_W-1:0]     i_baud_rate,
    output logic                           o_done,
    output logic [ubd_pkg::WORD_W-1:0]     o_divisor_word,
    output logic                           o_mantissa_clipped,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ubd_pkg::ADDR_W-1:0]     paddr,
    input  logic [ubd_pkg::DATA_W-1:0]     pwdata,
    output logic [ubd_pkg::DATA_W-1:0]     prdata,
    output logic                           pready
);

    logic [ubd_pkg::CLOCK_W-1:0] r_clock_hz;
    logic                        r_ob8;
    logic                        cfg_wr;
    ubd_pkg::t_reg_idx           reg_idx;

    logic                        r_front_valid;
    ubd_pkg::t_cell_data         r_front;
    ubd_pkg::t_cell_data         n_front;
    logic [ubd_pkg::PROD_W-1:0]  clk_scaled;

    logic                        chain_valid [ubd_pkg::NUM_CELLS+1];
    ubd_pkg::t_cell_data         chain_data  [ubd_pkg::NUM_CELLS+1];

    assign busy    = 1'b0;
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = ubd_pkg::t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_hz <= ubd_pkg::CLOCK_RESET;
            r_ob8      <= 1'b0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                ubd_pkg::REG_CLOCK_HZ:   r_clock_hz <= pwdata[ubd_pkg::CLOCK_W-1:0];
                ubd_pkg::REG_OVERSAMPLE: r_ob8      <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            ubd_pkg::REG_CLOCK_HZ:   prdata = ubd_pkg::DATA_W'(r_clock_hz);
            ubd_pkg::REG_OVERSAMPLE: prdata = ubd_pkg::DATA_W'(r_ob8);
            default:                 prdata = '0;
        endcase
    end

    // Front stage: dividend is clock*25 halved (by 8) or quartered (by 16)
    always_comb begin
        clk_scaled     = ubd_pkg::PROD_W'(r_clock_hz) * ubd_pkg::PROD_W'(ubd_pkg::SCALE_NUM);
        n_front        = '0;
        n_front.ob8    = r_ob8;
        // a zero baud rate divides as one
        n_front.baud   = (i_baud_rate == '0) ? ubd_pkg::BAUD_W'(1) : i_baud_rate;
        n_front.numer  = r_ob8 ? clk_scaled[ubd_pkg::PROD_W-1:1]
                               : {1'b0, clk_scaled[ubd_pkg::PROD_W-1:2]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_valid <= 1'b0;
        end else begin
            r_front_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_front <= n_front;
    end

    assign chain_valid[0] = r_front_valid;
    assign chain_data[0]  = r_front;

    for (genvar g = 0; g < ubd_pkg::NUM_CELLS; g++) begin : g_cell
        ubd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (chain_valid[g]),
            .i_data  (chain_data[g]),
            .o_valid (chain_valid[g+1]),
            .o_data  (chain_data[g+1])
        );
    end

    ubd_round u_round (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (chain_valid[ubd_pkg::NUM_CELLS]),
        .i_data    (chain_data[ubd_pkg::NUM_CELLS]),
        .o_valid   (o_done),
        .o_word    (o_divisor_word),
        .o_clipped (o_mantissa_clipped)
    );

endmodule

// ----- rtl/core/ubd_cell.sv -----
// ----------------------------------------------------------------------------
// ubd_cell
// One divider cell: retires one quotient bit of numer / baud and feeds it
// straight into a restoring divide by 100.
// ----------------------------------------------------------------------------
module ubd_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  ubd_pkg::t_cell_data i_data,
    output logic                o_valid,
    output ubd_pkg::t_cell_data o_data
);

    logic                r_valid;
    ubd_pkg::t_cell_data r_data;
    ubd_pkg::t_cell_data n_data;

    logic [ubd_pkg::BAUD_W:0] trial;
    logic [ubd_pkg::BAUD_W:0] diff;
    logic                     qbit;
    logic [ubd_pkg::REM_W:0]  dec;
    logic                     mbit;

    always_comb begin
        trial = {i_data.prem, i_data.numer[ubd_pkg::NUMER_W-1]};
        diff  = trial - {1'b0, i_data.baud};
        qbit  = (trial >= {1'b0, i_data.baud});

        // quotient bits arrive MSB first: fold them into the divide by 100
        dec   = {i_data.rem100, qbit};
        mbit  = (dec >= ubd_pkg::PCT);

        n_data        = i_data;
        n_data.numer  = {i_data.numer[ubd_pkg::NUMER_W-2:0], 1'b0};
        n_data.prem   = qbit ? diff[ubd_pkg::BAUD_W-1:0] : trial[ubd_pkg::BAUD_W-1:0];
        n_data.rem100 = mbit ? ubd_pkg::REM_W'(dec - ubd_pkg::PCT) : dec[ubd_pkg::REM_W-1:0];
        n_data.mant   = {i_data.mant[ubd_pkg::MANT_W-2:0], mbit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- rtl/core/ubd_round.sv -----
// ----------------------------------------------------------------------------
// ubd_round
// Rounds the remainder to eighths or sixteenths, carries a full unit into the
// mantissa, masks the mantissa and packs the divisor word.
// ----------------------------------------------------------------------------
module ubd_round (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  ubd_pkg::t_cell_data          i_data,
    output logic                         o_valid,
    output logic [ubd_pkg::WORD_W-1:0]   o_word,
    output logic                         o_clipped
);

    logic                          r_valid;
    logic [ubd_pkg::WORD_W-1:0]    r_word;
    logic                          r_clipped;
    logic [ubd_pkg::WORD_W-1:0]    n_word;
    logic                          n_clipped;

    logic [10:0]                   scaled;
    logic [21:0]                   prod;
    logic [4:0]                    frac;
    logic [4:0]                    steps;
    logic                          carry;
    logic [ubd_pkg::MANT_W-1:0]    mant;
    logic [ubd_pkg::FRAC_W-1:0]    frac_out;

    always_comb begin
        scaled = i_data.ob8 ? (11'({i_data.rem100, 3'b000}) + ubd_pkg::HALF_PCT)
                            : (11'({i_data.rem100, 4'b0000}) + ubd_pkg::HALF_PCT);
        prod   = 22'(scaled) * 22'(ubd_pkg::RECIP_100);
        frac   = prod[ubd_pkg::RECIP_SHIFT+4:ubd_pkg::RECIP_SHIFT];
        steps  = i_data.ob8 ? ubd_pkg::STEPS_8 : ubd_pkg::STEPS_16;
        carry  = (frac >= steps);

        // a whole unit of fraction moves into the mantissa
        mant     = i_data.mant + ubd_pkg::MANT_W'(carry);
        frac_out = carry ? '0
                 : (frac[ubd_pkg::FRAC_W-1:0] &
                    (i_data.ob8 ? ubd_pkg::FRAC8_MASK : ubd_pkg::FRAC16_MASK));

        n_clipped = (mant > ubd_pkg::MANT_W'(ubd_pkg::MANT_MASK));
        n_word    = {mant[11:0] & ubd_pkg::MANT_MASK, frac_out};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word    <= n_word;
        r_clipped <= n_clipped;
    end

    assign o_valid   = r_valid;
    assign o_word    = r_word;
    assign o_clipped = r_clipped;

endmodule

// ----- rtl/core/ubd_chk.sv -----
// ----------------------------------------------------------------------------
// ubd_chk
// Port-level checks for the baud divisor calculator.
// ----------------------------------------------------------------------------
module ubd_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           o_done,
    input logic                           psel,
    input logic                           penable,
    input logic                           pwrite,
    input logic                           pready,
    input logic [ubd_pkg::ADDR_W-1:0]     paddr,
    input logic [ubd_pkg::DATA_W-1:0]     pwdata,
    input logic [ubd_pkg::DATA_W-1:0]     prdata
);

    // every request yields its result after the fixed latency
    a_req_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(ubd_pkg::LATENCY) o_done)
        else $error("request produced no result at the expected cycle");

    // no result without a request at the matching earlier cycle
    a_done_from_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, ubd_pkg::LATENCY))
        else $error("result strobe without a matching request");

    // oversampling mode written then read back
    a_mode_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && pready && paddr[2]) ##1 (psel && !pwrite && paddr[2])
        |-> (prdata == {31'b0, $past(pwdata[0])}))
        else $error("oversampling mode readback mismatch");

endmodule

bind uart_baud_divisor_calc_top ubd_chk u_ubd_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .pready  (pready),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata)
);
